### rtl/ufs_pkg.sv
// Shared types and constants for the UDP port frame steering block.
package ufs_pkg;

   localparam int QUEUE_SLOTS = 64;
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 64;

   localparam logic [6:0]  POS_MAX         = 7'd127;
   localparam logic [6:0]  POS_TYPE_HI     = 7'd12;
   localparam logic [6:0]  POS_TYPE_LO     = 7'd13;
   localparam logic [6:0]  POS_IHL         = 7'd14;
   localparam logic [6:0]  POS_PROTO       = 7'd23;
   localparam logic [6:0]  ETH_HDR_LEN     = 7'd14;
   localparam logic [7:0]  MIN_FRAME_LEN   = 8'd34;
   localparam logic [7:0]  UDP_HDR_LEN     = 8'd8;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [15:0] PORT_RESET      = 16'd9876;
   localparam logic [8:0]  QUEUE_LIMIT     = 9'(QUEUE_SLOTS);

   typedef enum logic {
      REG_MATCH_PORT  = 1'b0,
      REG_SOCKET_MASK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        candidate;
      logic [15:0] dest_port;
      logic [7:0]  queue;
   } entry_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } fifo_status_type;

endpackage

### rtl/ufs_csr.sv
// Configuration registers behind the APB-style port.
module ufs_csr import ufs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [15:0]       match_port,
   output logic [63:0]       socket_mask
);

   logic [15:0]   match_port_ff, match_port_in;
   logic [63:0]   socket_mask_ff, socket_mask_in;
   logic          wr_en;
   csr_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[3]);

   always_comb begin
      match_port_in  = match_port_ff;
      socket_mask_in = socket_mask_ff;
      prdata         = '0;
      unique case (index)
         REG_MATCH_PORT: begin
            prdata = DATA_W'(match_port_ff);
            if (wr_en) match_port_in = pwdata[15:0];
         end
         REG_SOCKET_MASK: begin
            prdata = socket_mask_ff;
            if (wr_en) socket_mask_in = pwdata;
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_port_ff  <= PORT_RESET;
         socket_mask_ff <= '0;
      end else begin
         match_port_ff  <= match_port_in;
         socket_mask_ff <= socket_mask_in;
      end
   end

   assign match_port  = match_port_ff;
   assign socket_mask = socket_mask_ff;

endmodule

### rtl/ufs_front.sv
// Byte parser: captures header fields and classifies each frame on its last byte.
module ufs_front import ufs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      frame_byte,
   input  logic            end_of_frame,
   input  logic [7:0]      queue_number,
   output logic            push,
   output entry_type       push_entry
);

   logic [6:0]  pos_ff, pos_in;
   logic [15:0] ether_ff, ether_in;
   logic [3:0]  hw_ff, hw_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] port_ff, port_in;
   logic [6:0]  udp_off;
   logic [7:0]  length;
   logic [7:0]  need;

   assign udp_off = ETH_HDR_LEN + {1'b0, hw_ff, 2'b00};

   always_comb begin
      pos_in     = pos_ff;
      ether_in   = ether_ff;
      hw_in      = hw_ff;
      proto_in   = proto_ff;
      port_in    = port_ff;
      push       = 1'b0;
      length     = {1'b0, pos_ff} + 8'd1;
      need       = '0;
      push_entry = '0;
      if (accept) begin
         if (pos_ff == POS_TYPE_HI)      ether_in[15:8] = frame_byte;
         else if (pos_ff == POS_TYPE_LO) ether_in[7:0]  = frame_byte;
         else if (pos_ff == POS_IHL)     hw_in          = frame_byte[3:0];
         else if (pos_ff == POS_PROTO)   proto_in       = frame_byte;
         if (pos_ff > POS_IHL && pos_ff < POS_MAX) begin
            if (pos_ff == udp_off + 7'd2)      port_in[15:8] = frame_byte;
            else if (pos_ff == udp_off + 7'd3) port_in[7:0]  = frame_byte;
         end
         need = {1'b0, ETH_HDR_LEN} + UDP_HDR_LEN + {2'b00, hw_in, 2'b00};
         if (end_of_frame) begin
            push                 = 1'b1;
            push_entry.candidate = (length >= MIN_FRAME_LEN) && (length >= need) &&
                                   (ether_in == ETHERTYPE_IPV4) && (proto_in == PROTO_UDP);
            push_entry.dest_port = port_in;
            push_entry.queue     = queue_number;
            pos_in   = '0;
            ether_in = '0;
            hw_in    = '0;
            proto_in = '0;
            port_in  = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ether_ff <= '0;
         hw_ff    <= '0;
         proto_ff <= '0;
         port_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         ether_ff <= ether_in;
         hw_ff    <= hw_in;
         proto_ff <= proto_in;
         port_ff  <= port_in;
      end
   end

endmodule

### rtl/ufs_fifo.sv
// Short queue of classified frames between parser and verdict stage.
module ufs_fifo import ufs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  entry_type       push_entry,
   input  logic            pop,
   output entry_type       head,
   output fifo_status_type status
);

   entry_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full       = (count_ff == CNT_W'(FIFO_DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign do_push           = push && !status.full;
   assign do_pop            = pop && status.head_valid;
   assign head              = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/ufs_back.sv
// Verdict stage: port and socket checks, result output register.
module ufs_back import ufs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  entry_type       head,
   input  fifo_status_type status,
   output logic            pop,
   input  logic [15:0]     match_port,
   input  logic [63:0]     socket_mask,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_verdict,
   output logic [7:0]      rsp_target_queue
);

   logic       valid_ff, valid_in;
   logic       verdict_ff, verdict_in;
   logic [7:0] queue_ff, queue_in;
   logic       open_slot;

   assign open_slot = !valid_ff || !rsp_stall;
   assign pop       = open_slot && status.head_valid;

   always_comb begin
      valid_in   = valid_ff;
      verdict_in = verdict_ff;
      queue_in   = queue_ff;
      if (pop) begin
         valid_in   = 1'b1;
         verdict_in = head.candidate && (head.dest_port == match_port) &&
                      ({1'b0, head.queue} < QUEUE_LIMIT) && socket_mask[head.queue[5:0]];
         queue_in   = head.queue;
      end else if (open_slot) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      queue_ff   <= queue_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_target_queue = queue_ff;

endmodule

### rtl/udp_port_frame_steering_core.sv
// Top level of the UDP port frame steering block.
//
//   channel  direction  transfer                         handshake
//   req      in         one frame byte, last flag, queue  req_valid / req_stall
//   rsp      out        verdict and target queue          rsp_valid / rsp_stall
//   csr      in         match port, socket mask           psel / penable / pready
//
// One byte per cycle while req_stall is low. After the last byte's transfer, the verdict passes
// through the four-entry frame queue and then the output register, which loads once it is free.
// Reset is synchronous and active high; it clears the parser, queue and output valid.
// req_stall is high only while the frame queue is full, which happens only after
// rsp_stall has held results back for several frames.
module udp_port_frame_steering_core import ufs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_end_of_frame,
   input  logic [7:0]        req_queue_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_verdict,
   output logic [7:0]        rsp_target_queue,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic            accept;
   logic            push;
   logic            pop;
   entry_type       push_entry;
   entry_type       head;
   fifo_status_type status;
   logic [15:0]     match_port;
   logic [63:0]     socket_mask;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   ufs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .match_port  (match_port),
      .socket_mask (socket_mask)
   );

   ufs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_byte   (req_frame_byte),
      .end_of_frame (req_end_of_frame),
      .queue_number (req_queue_number),
      .push         (push),
      .push_entry   (push_entry)
   );

   ufs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   ufs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .status           (status),
      .pop              (pop),
      .match_port       (match_port),
      .socket_mask      (socket_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_target_queue (rsp_target_queue)
   );

endmodule

### rtl/ufs_checker.sv
// Port-level checks for the steering core, bound to the top level.
module ufs_checker import ufs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_verdict,
   input logic [7:0]        rsp_target_queue,
   input logic              pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict) &&
                                 $stable(rsp_target_queue))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready dropped");

   a_redirect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict |-> {1'b0, rsp_target_queue} < QUEUE_LIMIT)
      else $error("redirect to queue out of range");

endmodule

bind udp_port_frame_steering_core ufs_checker u_ufs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_verdict      (rsp_verdict),
   .rsp_target_queue (rsp_target_queue),
   .pready           (pready)
);
